### src/bdse_pkg.sv
// Package for the bounded deque search engine: sizes, request codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package bdse_pkg;

    localparam int Capacity  = 64;
    localparam int DataWidth = 32;
    localparam int PtrW      = $clog2(Capacity);
    localparam int CntW      = $clog2(Capacity + 1);

    typedef enum logic [3:0] {
        REQ_PUSH_BACK  = 4'd0,
        REQ_PUSH_FRONT = 4'd1,
        REQ_POP_BACK   = 4'd2,
        REQ_POP_FRONT  = 4'd3,
        REQ_INCLUDES   = 4'd4,
        REQ_READ_AT    = 4'd5,
        REQ_INSERT_AT  = 4'd6,
        REQ_REMOVE_AT  = 4'd7,
        REQ_SIZE       = 4'd8,
        REQ_FIRST_IDX  = 4'd9,
        REQ_LAST_IDX   = 4'd10,
        REQ_NTH_IDX    = 4'd11,
        REQ_COUNT      = 4'd12,
        REQ_RSVD13     = 4'd13,
        REQ_RSVD14     = 4'd14,
        REQ_RSVD15     = 4'd15
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_WALK,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic rd;       // issue memory read (walk index, last entry or position slot)
        logic step;     // handle data of previous read (compare, count hits, move entry)
        logic finish;   // commit and present result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_walk;  // request needs a walk over store entries
        logic walk_end; // last read already issued
        logic hit_stop; // search may stop early
    } t_sts;

endpackage

### src/bdse_ctrl.sv
// Controller FSM for the bounded deque search engine.
// Depends on bdse_pkg.
module bdse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bdse_pkg::t_sts  i_sts,
    output bdse_pkg::t_cmd  o_cmd
);
    import bdse_pkg::*;

    t_state r_state, n_state;
    logic   r_pend;  // a read is in flight during walk

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= o_cmd.rd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_DECIDE;
            S_DECIDE: n_state = i_sts.is_walk ? S_WALK : S_READ;
            S_READ:   n_state = S_DONE;
            S_WALK: begin
                if ((r_pend && i_sts.hit_stop) || (!r_pend && i_sts.walk_end))
                    n_state = S_DONE;
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_DECIDE: o_cmd = '0;
            S_READ:   o_cmd.rd = 1'b1;
            S_WALK: begin
                o_cmd.step = r_pend;
                o_cmd.rd   = !i_sts.walk_end && !(r_pend && i_sts.hit_stop);
            end
            S_DONE:   o_cmd.finish = 1'b1;
            default:  o_cmd = '0;
        endcase
    end
endmodule

### src/bdse_dpath.sv
// Datapath for the bounded deque search engine: ring store, pointers,
// walk counter, compare and result registers. Depends on bdse_pkg.
module bdse_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bdse_pkg::t_cmd               i_cmd,
    output bdse_pkg::t_sts               o_sts,
    input  logic [3:0]                   i_req_type,
    input  logic signed [31:0]           i_item_value,
    input  logic [5:0]                   i_position_in,
    input  logic [5:0]                   i_occurrence,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic                         o_found,
    output logic signed [31:0]           o_value_out,
    output logic [5:0]                   o_position_out,
    output logic [6:0]                   o_tally,
    output logic [6:0]                   o_occupancy
);
    import bdse_pkg::*;

    logic [DataWidth-1:0] mem [Capacity];

    t_req                 r_req;
    logic [DataWidth-1:0] r_key;
    logic [PtrW-1:0]      r_pos, r_nth;
    logic [PtrW-1:0]      r_front;
    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      r_idx;      // index of next read
    logic [CntW-1:0]      r_pidx;     // index of data in r_rdata
    logic [DataWidth-1:0] r_rdata;
    logic [CntW-1:0]      r_hits;
    logic                 r_found;
    logic [PtrW-1:0]      r_pout;
    logic [1:0]           r_err;
    logic                 r_valid;
    logic [1:0]           r_status;
    logic                 r_ofound;
    logic [DataWidth-1:0] r_vout;
    logic [PtrW-1:0]      r_opos;
    logic [CntW-1:0]      r_tally;
    logic [CntW-1:0]      r_occ;

    logic            full, empty, bad_int, hit, is_search, desc;
    logic [PtrW-1:0] rd_slot, wr_slot;
    logic [CntW-1:0] wr_idx;
    logic            wr_en;
    logic [DataWidth-1:0] wr_data;

    assign full    = (r_count >= CntW'(Capacity));
    assign empty   = (r_count == '0);
    assign bad_int = (r_pos == '0) || ({1'b0, r_pos} + CntW'(1) >= r_count);
    assign hit     = (r_rdata == r_key);
    assign is_search = (r_req == REQ_INCLUDES) || (r_req == REQ_FIRST_IDX)
                    || (r_req == REQ_LAST_IDX) || (r_req == REQ_NTH_IDX)
                    || (r_req == REQ_COUNT);
    assign desc = (r_req == REQ_LAST_IDX) || (r_req == REQ_INSERT_AT);

    // walk control: whether to walk, end bound and early stop
    always_comb begin
        o_sts.is_walk  = 1'b0;
        o_sts.walk_end = 1'b0;
        o_sts.hit_stop = 1'b0;
        case (r_req)
            REQ_INCLUDES, REQ_FIRST_IDX, REQ_LAST_IDX, REQ_NTH_IDX, REQ_COUNT:
                o_sts.is_walk = 1'b1;
            REQ_INSERT_AT: o_sts.is_walk = !bad_int && !full;
            REQ_REMOVE_AT: o_sts.is_walk = !bad_int;
            default:       o_sts.is_walk = 1'b0;
        endcase
        case (r_req)
            REQ_LAST_IDX:  o_sts.walk_end = (r_idx == '0);
            REQ_INSERT_AT: o_sts.walk_end = (r_idx <= {1'b0, r_pos});
            REQ_REMOVE_AT: o_sts.walk_end = (r_idx >= r_count);
            default:       o_sts.walk_end = (r_idx >= r_count);
        endcase
        case (r_req)
            REQ_INCLUDES, REQ_FIRST_IDX, REQ_LAST_IDX: o_sts.hit_stop = hit;
            REQ_NTH_IDX: o_sts.hit_stop = hit && (r_hits == {1'b0, r_nth});
            default:     o_sts.hit_stop = 1'b0;
        endcase
    end

    // read address: walk index (last_idx and insert read idx-1), last entry for pop_back, position for read_at
    always_comb begin
        rd_slot = r_front + r_idx[PtrW-1:0];
        if (r_req == REQ_POP_BACK) rd_slot = r_front + PtrW'(r_count - CntW'(1));
        else if (r_req == REQ_READ_AT) rd_slot = r_front + r_pos;
        else if (desc) rd_slot = r_front + PtrW'(r_idx - CntW'(1));
    end

    // writes: moves during insert/remove walk, end items and inserted item at finish
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = r_rdata;
        wr_slot = '0;
        if (i_cmd.step && r_req == REQ_INSERT_AT) begin
            wr_en = 1'b1; wr_idx = r_pidx + CntW'(1);
        end else if (i_cmd.step && r_req == REQ_REMOVE_AT && r_pidx != '0) begin
            wr_en = 1'b1; wr_idx = r_pidx - CntW'(1);
        end else if (i_cmd.finish && r_err == ST_OK) begin
            wr_data = r_key;
            case (r_req)
                REQ_PUSH_BACK:  begin wr_en = 1'b1; wr_idx = r_count; end
                REQ_INSERT_AT:  begin wr_en = 1'b1; wr_idx = {1'b0, r_pos}; end
                default:        wr_en = 1'b0;
            endcase
        end
        wr_slot = r_front + wr_idx[PtrW-1:0];
        if (i_cmd.finish && r_req == REQ_PUSH_FRONT && r_err == ST_OK) begin
            wr_en = 1'b1; wr_data = r_key; wr_slot = r_front - PtrW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_slot] <= wr_data;
        if (i_cmd.rd) r_rdata <= mem[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish && r_err == ST_OK) begin
                case (r_req)
                    REQ_PUSH_BACK, REQ_INSERT_AT: r_count <= r_count + CntW'(1);
                    REQ_PUSH_FRONT: begin
                        r_count <= r_count + CntW'(1);
                        r_front <= r_front - PtrW'(1);
                    end
                    REQ_POP_BACK, REQ_REMOVE_AT: r_count <= r_count - CntW'(1);
                    REQ_POP_FRONT: begin
                        r_count <= r_count - CntW'(1);
                        r_front <= r_front + PtrW'(1);
                    end
                    default: r_count <= r_count;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= t_req'(i_req_type);
            r_key   <= i_item_value[DataWidth-1:0];
            r_pos   <= i_position_in;
            r_nth   <= i_occurrence;
            r_hits  <= '0;
            r_found <= 1'b0;
            r_pout  <= '0;
        end
        if (i_cmd.rd) begin
            r_pidx <= desc ? r_idx - CntW'(1) : r_idx;
            r_idx  <= desc ? r_idx - CntW'(1) : r_idx + CntW'(1);
        end
        if (i_cmd.step && is_search && hit) begin
            r_hits <= r_hits + CntW'(1);
            if (o_sts.hit_stop) begin
                r_found <= 1'b1;
                r_pout  <= r_pidx[PtrW-1:0];
            end
        end
        // whenever no command is active (decide stage, also idle): set start index and error
        if (!i_cmd.load && !i_cmd.rd && !i_cmd.step && !i_cmd.finish) begin
            r_idx <= '0;
            if (r_req == REQ_LAST_IDX || r_req == REQ_INSERT_AT) r_idx <= r_count;
            else if (r_req == REQ_REMOVE_AT) r_idx <= {1'b0, r_pos} + CntW'(1);
            r_pidx <= {1'b0, r_pos};
            case (r_req)
                REQ_PUSH_BACK, REQ_PUSH_FRONT:
                    r_err <= full ? ST_OVERFLOW : ST_OK;
                REQ_POP_BACK, REQ_POP_FRONT:
                    r_err <= empty ? ST_UNDERFLOW : ST_OK;
                REQ_READ_AT:
                    r_err <= ({1'b0, r_pos} >= r_count) ? ST_BAD_INDEX : ST_OK;
                REQ_INSERT_AT:
                    r_err <= bad_int ? ST_BAD_INDEX : (full ? ST_OVERFLOW : ST_OK);
                REQ_REMOVE_AT:
                    r_err <= bad_int ? ST_BAD_INDEX : ST_OK;
                default: r_err <= ST_OK;
            endcase
        end
        if (i_cmd.finish) begin
            r_status <= r_err;
            r_ofound <= 1'b0;
            r_vout   <= '0;
            r_opos   <= '0;
            r_tally  <= '0;
            r_occ    <= r_count;
            case (r_req)
                REQ_POP_BACK, REQ_POP_FRONT: if (r_err == ST_OK) begin
                    r_vout <= r_rdata;
                    r_occ  <= r_count - CntW'(1);
                end
                REQ_READ_AT: if (r_err == ST_OK) begin
                    r_vout   <= r_rdata;
                    r_ofound <= 1'b1;
                end
                REQ_INCLUDES, REQ_FIRST_IDX, REQ_LAST_IDX, REQ_NTH_IDX: begin
                    r_ofound <= r_found;
                    r_opos   <= r_pout;
                end
                REQ_COUNT: r_tally <= r_hits;
                REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT_AT:
                    if (r_err == ST_OK) r_occ <= r_count + CntW'(1);
                REQ_REMOVE_AT:
                    if (r_err == ST_OK) r_occ <= r_count - CntW'(1);
                default: r_occ <= r_count;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found        = r_ofound;
    assign o_value_out    = 32'(signed'(r_vout));
    assign o_position_out = r_opos;
    assign o_tally        = 7'(r_tally);
    assign o_occupancy    = 7'(r_occ);
endmodule

### src/bounded_deque_search_engine.sv
// Bounded deque search engine: ring-stored deque of signed values with search.
// Walks (search, count, insert, remove) read one store entry per cycle;
// end ops and size do not walk.
// One request at a time; busy is high from acceptance until the strobe.
// Synchronous active-low reset empties the deque; store contents persist.
// Results appear on o_valid for one cycle; the receiver cannot stall.
module bounded_deque_search_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_req_type,
    input  logic signed [31:0] i_item_value,
    input  logic [5:0]         i_position_in,
    input  logic [5:0]         i_occurrence,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic signed [31:0] o_value_out,
    output logic [5:0]         o_position_out,
    output logic [6:0]         o_tally,
    output logic [6:0]         o_occupancy
);
    import bdse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bdse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sts(sts), .o_cmd(cmd)
    );

    bdse_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_req_type(i_req_type), .i_item_value(i_item_value),
        .i_position_in(i_position_in), .i_occurrence(i_occurrence),
        .o_valid(o_valid), .o_status(o_status), .o_found(o_found),
        .o_value_out(o_value_out), .o_position_out(o_position_out),
        .o_tally(o_tally), .o_occupancy(o_occupancy)
    );
endmodule

### src/bdse_checker.sv
// Port-level checker for the bounded deque search engine, bound to the top.
// Depends on bdse_pkg.
module bdse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_status,
    input logic       o_found,
    input logic [6:0] o_tally,
    input logic [6:0] o_occupancy
);
    import bdse_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("start not taken");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_occupancy <= 7'(Capacity)) else $error("occupancy too big");
    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tally <= o_occupancy) else $error("tally too big");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == ST_OK) else $error("found with error");
endmodule

bind bounded_deque_search_engine bdse_checker u_bdse_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_status(o_status), .o_found(o_found),
    .o_tally(o_tally), .o_occupancy(o_occupancy)
);

### verif/tb_bounded_deque_search_engine.sv
// Testbench for bounded_deque_search_engine: directed and random requests,
// each response checked field by field against an in-bench deque model.
// Depends on bdse_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_bounded_deque_search_engine;
    import bdse_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
        logic [5:0]  position_out;
        logic [6:0]  tally;
        logic [6:0]  occupancy;
    } t_resp;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_req_type;
    logic signed [31:0] i_item_value;
    logic [5:0]         i_position_in;
    logic [5:0]         i_occurrence;
    logic               o_valid;
    logic [1:0]         o_status;
    logic               o_found;
    logic signed [31:0] o_value_out;
    logic [5:0]         o_position_out;
    logic [6:0]         o_tally;
    logic [6:0]         o_occupancy;

    bounded_deque_search_engine u_top (.*);

    logic [31:0] deque_vals[$];
    t_resp       pending_resps[$];
    int          err_count = 0;
    int          send_idle_pct;
    longint      cycle_count = 0;

    localparam longint CycleLimit = 400000;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_resp deque_apply(t_req req, logic [31:0] val, int pos, int nth);
        t_resp r;
        int n;
        int hits;
        r = '0;
        n = deque_vals.size();
        case (req)
            REQ_PUSH_BACK: begin
                if (n >= Capacity) r.status = ST_OVERFLOW;
                else deque_vals.push_back(val);
            end
            REQ_PUSH_FRONT: begin
                if (n >= Capacity) r.status = ST_OVERFLOW;
                else deque_vals.push_front(val);
            end
            REQ_POP_BACK: begin
                if (n == 0) r.status = ST_UNDERFLOW;
                else r.value_out = deque_vals.pop_back();
            end
            REQ_POP_FRONT: begin
                if (n == 0) r.status = ST_UNDERFLOW;
                else r.value_out = deque_vals.pop_front();
            end
            REQ_INCLUDES, REQ_FIRST_IDX: begin
                for (int i = 0; i < n; i++)
                    if (deque_vals[i] == val) begin
                        r.found = 1'b1;
                        r.position_out = 6'(i);
                        break;
                    end
            end
            REQ_READ_AT: begin
                if (pos >= n) r.status = ST_BAD_INDEX;
                else begin
                    r.found = 1'b1;
                    r.value_out = deque_vals[pos];
                end
            end
            REQ_INSERT_AT: begin
                if (pos == 0 || pos + 1 >= n) r.status = ST_BAD_INDEX;
                else if (n >= Capacity) r.status = ST_OVERFLOW;
                else deque_vals.insert(pos, val);
            end
            REQ_REMOVE_AT: begin
                if (pos == 0 || pos + 1 >= n) r.status = ST_BAD_INDEX;
                else deque_vals.delete(pos);
            end
            REQ_LAST_IDX: begin
                for (int i = n - 1; i >= 0; i--)
                    if (deque_vals[i] == val) begin
                        r.found = 1'b1;
                        r.position_out = 6'(i);
                        break;
                    end
            end
            REQ_NTH_IDX: begin
                hits = 0;
                for (int i = 0; i < n; i++)
                    if (deque_vals[i] == val) begin
                        if (hits == nth) begin
                            r.found = 1'b1;
                            r.position_out = 6'(i);
                            break;
                        end
                        hits++;
                    end
            end
            REQ_COUNT: begin
                hits = 0;
                for (int i = 0; i < n; i++)
                    if (deque_vals[i] == val) hits++;
                r.tally = 7'(hits);
            end
            default: ;
        endcase
        r.occupancy = 7'(deque_vals.size());
        return r;
    endfunction

    task automatic send_request(t_req req, logic [31:0] val, int pos, int nth);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        start         <= 1'b1;
        i_req_type    <= req;
        i_item_value  <= val;
        i_position_in <= 6'(pos);
        i_occurrence  <= 6'(nth);
        do @(posedge i_clk); while (busy);
        pending_resps.push_back(deque_apply(req, val, pos, nth));
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_resps.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_resp got;
        t_resp exp_r;
        cycle_count <= cycle_count + 1;
        if (o_valid) begin
            got = {o_status, o_found, o_value_out, o_position_out, o_tally, o_occupancy};
            if (pending_resps.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $realtime, got);
                err_count++;
            end else begin
                exp_r = pending_resps.pop_front();
                if (got.status !== exp_r.status)
                    $display("%0t: status exp %0d act %0d", $realtime, exp_r.status, got.status);
                if (got.found !== exp_r.found)
                    $display("%0t: found exp %0d act %0d", $realtime, exp_r.found, got.found);
                if (got.value_out !== exp_r.value_out)
                    $display("%0t: value exp %h act %h", $realtime, exp_r.value_out, got.value_out);
                if (got.position_out !== exp_r.position_out)
                    $display("%0t: position exp %0d act %0d", $realtime,
                             exp_r.position_out, got.position_out);
                if (got.tally !== exp_r.tally)
                    $display("%0t: tally exp %0d act %0d", $realtime, exp_r.tally, got.tally);
                if (got.occupancy !== exp_r.occupancy)
                    $display("%0t: occupancy exp %0d act %0d", $realtime,
                             exp_r.occupancy, got.occupancy);
                if (got !== exp_r) err_count++;
            end
        end
        if (cycle_count > CycleLimit) begin
            $display("tb_bounded_deque_search_engine: done, errors");
            $finish;
        end
    end

    // extremes, every defined request code and two reserved ones, empty/one-entry cases
    task automatic test_directed();
        send_request(REQ_POP_BACK, 32'd0, 0, 0);
        send_request(REQ_POP_FRONT, 32'd0, 0, 0);
        send_request(REQ_READ_AT, 32'd0, 0, 0);
        send_request(REQ_INCLUDES, 32'd5, 0, 0);
        send_request(REQ_PUSH_BACK, 32'h8000_0000, 0, 0);
        send_request(REQ_POP_FRONT, 32'd0, 0, 0);
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF, 0, 0);
        send_request(REQ_POP_BACK, 32'd0, 0, 0);
        send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 0, 0);
        send_request(REQ_PUSH_BACK, 32'd7, 0, 0);
        send_request(REQ_PUSH_FRONT, 32'd7, 0, 0);
        send_request(REQ_INSERT_AT, 32'd7, 1, 0);
        send_request(REQ_INSERT_AT, 32'd1, 0, 0);
        send_request(REQ_INSERT_AT, 32'd1, 3, 0);
        send_request(REQ_REMOVE_AT, 32'd0, 3, 0);
        send_request(REQ_REMOVE_AT, 32'd0, 2, 0);
        send_request(REQ_FIRST_IDX, 32'd7, 0, 0);
        send_request(REQ_LAST_IDX, 32'd7, 0, 0);
        send_request(REQ_NTH_IDX, 32'd7, 0, 1);
        send_request(REQ_NTH_IDX, 32'd7, 0, 63);
        send_request(REQ_COUNT, 32'd7, 0, 0);
        send_request(REQ_SIZE, 32'd0, 0, 0);
        send_request(REQ_READ_AT, 32'd0, 63, 0);
        send_request(REQ_RSVD13, 32'd0, 0, 0);
        send_request(REQ_RSVD15, 32'hFFFF_FFFF, 63, 63);
    endtask

    // fill to capacity, overflow pushes and inserts, then drain past empty
    task automatic test_full_empty();
        while (deque_vals.size() < Capacity) send_request(REQ_PUSH_BACK, $urandom_range(3), 0, 0);
        send_request(REQ_PUSH_BACK, 32'd1, 0, 0);
        send_request(REQ_PUSH_FRONT, 32'd1, 0, 0);
        send_request(REQ_INSERT_AT, 32'd1, 5, 0);
        send_request(REQ_COUNT, 32'd2, 0, 0);
        send_request(REQ_READ_AT, 32'd0, 63, 0);
        send_request(REQ_NTH_IDX, 32'd1, 0, 10);
        wait_drained();
        while (deque_vals.size() > 0) send_request(REQ_POP_FRONT, 32'd0, 0, 0);
        send_request(REQ_POP_FRONT, 32'd0, 0, 0);
    endtask

    task automatic test_random(int n_items);
        t_req req;
        logic [31:0] val;
        int n;
        for (int k = 0; k < n_items; k++) begin
            n = deque_vals.size();
            req = t_req'($urandom_range(15));
            if ($urandom_range(3) == 0) val = $urandom();
            else val = $urandom_range(5) - 2;
            if ((req == REQ_POP_BACK || req == REQ_POP_FRONT) && n > 8 && $urandom_range(1))
                req = REQ_PUSH_BACK;
            send_request(req, val,
                         (n > 0 && $urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(63),
                         $urandom_range(3) != 0 ? $urandom_range(3) : $urandom_range(63));
        end
    endtask

    initial begin
        int tail;
        send_idle_pct = 18;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = '0;
        i_item_value  = '0;
        i_position_in = '0;
        i_occurrence  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_empty();
        test_random(115);
        wait_drained();
        send_idle_pct = 63;
        test_random(115);
        send_idle_pct = 0;
        test_random(115);
        wait_drained();
        tail = 0;
        while (tail < 100) begin
            @(negedge i_clk);
            tail++;
        end
        if (err_count == 0) $display("tb_bounded_deque_search_engine: done, clean");
        else $display("tb_bounded_deque_search_engine: done, errors");
        $finish;
    end
endmodule
